// ===== hdl/tet_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tet_pkg
// Shared types, character constants and match tables of the text escape
// transcoder.
// ----------------------------------------------------------------------------
package tet_pkg;

  localparam logic [7:0] CH_C2   = 8'hC2;
  localparam logic [7:0] CH_C3   = 8'hC3;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_G    = 8'h67;
  localparam logic [7:0] CH_T    = 8'h74;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UP   = 8'h50;
  localparam logic [7:0] ESC_OFS = 8'h31;

  localparam int REP_MAX        = 5;
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef enum logic [2:0] {
    PK_CONV,
    PK_NEW,
    PK_ESC,
    PK_LF,
    PK_HASH
  } pass_kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       lead;
  } tok_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
  } pair_t;

  function automatic logic is_lead(pass_kind_t k, logic [7:0] b);
    logic r;
    r = 1'b0;
    unique case (k)
      PK_CONV: r = (b == CH_C2) || (b == CH_C3);
      PK_NEW:  r = (b == CH_C3);
      PK_ESC:  r = (b == CH_HASH);
      PK_HASH: r = (b == CH_HASH);
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic pair_t pair_lookup(pass_kind_t k, logic [7:0] p, logic [7:0] b);
    pair_t r;
    r.hit  = 1'b0;
    r.code = 8'h00;
    unique case (k)
      PK_CONV: begin
        r.hit = 1'b1;
        unique case ({p, b})
          16'hC2AA: r.code = 8'd16;
          16'hC2A1: r.code = 8'd17;
          16'hC2BF: r.code = 8'd18;
          16'hC2AB: r.code = 8'd19;
          16'hC2BB: r.code = 8'd20;
          16'hC3A1: r.code = 8'd21;
          16'hC3A9: r.code = 8'd22;
          16'hC3AD: r.code = 8'd23;
          16'hC3B3: r.code = 8'd24;
          16'hC3BA: r.code = 8'd25;
          16'hC3B1: r.code = 8'd26;
          16'hC391: r.code = 8'd27;
          16'hC3A7: r.code = 8'd28;
          16'hC387: r.code = 8'd29;
          16'hC3BC: r.code = 8'd30;
          16'hC39C: r.code = 8'd31;
          default:  r.hit  = 1'b0;
        endcase
      end
      PK_NEW: begin
        r.hit = 1'b1;
        unique case (b)
          8'hA0:   r.code = 8'd16;
          8'hA3:   r.code = 8'd17;
          8'hA4:   r.code = 8'd18;
          8'hA2:   r.code = 8'd19;
          8'hA8:   r.code = 8'd20;
          8'hAB:   r.code = 8'd21;
          8'hAA:   r.code = 8'd22;
          8'hAC:   r.code = 8'd23;
          8'hAF:   r.code = 8'd24;
          8'hAE:   r.code = 8'd25;
          8'hB2:   r.code = 8'd26;
          8'hB5:   r.code = 8'd27;
          8'hB6:   r.code = 8'd28;
          8'hB4:   r.code = 8'd29;
          8'hB9:   r.code = 8'd30;
          8'hBB:   r.code = 8'd31;
          8'h9F:   r.code = 8'd35;
          default: r.hit  = 1'b0;
        endcase
      end
      PK_ESC: begin
        r.hit = 1'b1;
        unique case (b)
          8'h67:   r.code = 8'h0E;
          8'h74:   r.code = 8'h0F;
          8'h62:   r.code = 8'h0B;
          8'h73:   r.code = 8'h20;
          8'h66:   r.code = 8'h7F;
          8'h6B:   r.code = 8'h0C;
          8'h6E:   r.code = 8'h0D;
          8'h72:   r.code = 8'h0D;
          default: begin
            r.hit  = (b >= CH_UA) && (b <= CH_UP);
            r.code = b - ESC_OFS;
          end
        endcase
      end
      PK_HASH: begin
        r.hit  = (b == CH_HASH);
        r.code = CH_HASH;
      end
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/tet_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tet_front
// Input register: takes raw bytes and tags bytes that open a UTF-8 pair.
// ----------------------------------------------------------------------------
module tet_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output logic          out_valid,
  input  logic          out_stall,
  output tet_pkg::tok_t out_tok
);
  import tet_pkg::*;

  logic fv_r, fv_nxt;
  tok_t tok_r;
  logic acc;

  always_comb begin
    in_stall  = fv_r && out_stall;
    acc       = in_valid && !in_stall;
    fv_nxt    = acc ? 1'b1 : (fv_r && out_stall);
    out_valid = fv_r;
    out_tok   = tok_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      tok_r.data <= in_byte;
      tok_r.last <= in_last;
      tok_r.lead <= is_lead(PK_CONV, in_byte);
    end
  end

endmodule

// ===== hdl/tet_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tet_queue
// Short FIFO between the front register and the pass chain.
// ----------------------------------------------------------------------------
module tet_queue #(
  parameter int DEPTH = tet_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  tet_pkg::tok_t in_tok,
  output logic          out_valid,
  input  logic          out_stall,
  output tet_pkg::tok_t out_tok
);
  import tet_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tok_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push, pop;

  always_comb begin
    in_stall   = (cnt_r == CW'(DEPTH));
    out_valid  = (cnt_r != '0);
    out_tok    = mem_r[rd_ptr_r];
    push       = in_valid && !in_stall;
    pop        = out_valid && !out_stall;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_tok;
    end
  end

endmodule

// ===== hdl/tet_pass.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tet_pass
// One merged replace pass: holds at most one lead byte, matches the next byte, and
// emits the replacement from a small shift buffer one byte per unstalled cycle.
// ----------------------------------------------------------------------------
module tet_pass #(
  parameter tet_pkg::pass_kind_t KIND      = tet_pkg::PK_CONV,
  parameter tet_pkg::pass_kind_t NEXT_KIND = tet_pkg::PK_NEW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  tet_pkg::tok_t in_tok,
  output logic          out_valid,
  input  logic          out_stall,
  output tet_pkg::tok_t out_tok
);
  import tet_pkg::*;

  localparam int CW = $clog2(REP_MAX + 1);

  logic [7:0]    obuf_r [REP_MAX];
  logic [7:0]    obuf_nxt [REP_MAX];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          olast_r, olast_nxt;
  logic          pv_r, pv_nxt;
  logic [7:0]    pend_r, pend_nxt;
  logic          acc, pop;
  pair_t         pr;
  logic [7:0]    plain;

  always_comb begin
    pr        = pair_lookup(KIND, pend_r, in_tok.data);
    plain     = (KIND == PK_LF && in_tok.data == CH_LF) ? CH_CR : in_tok.data;
    out_valid = (cnt_r != '0);
    pop       = out_valid && !out_stall;
    in_stall  = !((cnt_r == '0) || (cnt_r == CW'(1) && !out_stall));
    acc       = in_valid && !in_stall;

    obuf_nxt  = obuf_r;
    cnt_nxt   = cnt_r;
    olast_nxt = olast_r;
    pv_nxt    = pv_r;
    pend_nxt  = pend_r;

    if (pop) begin
      for (int i = 0; i < REP_MAX - 1; i++) begin
        obuf_nxt[i] = obuf_r[i+1];
      end
      cnt_nxt = CW'(cnt_r - 1'b1);
    end

    if (acc) begin
      olast_nxt = in_tok.last;
      pv_nxt    = 1'b0;
      if (pv_r && pr.hit) begin
        if (KIND == PK_NEW) begin
          obuf_nxt[0] = CH_HASH;
          obuf_nxt[1] = CH_G;
          obuf_nxt[2] = pr.code;
          obuf_nxt[3] = CH_HASH;
          obuf_nxt[4] = CH_T;
          cnt_nxt     = CW'(REP_MAX);
        end else begin
          obuf_nxt[0] = pr.code;
          cnt_nxt     = CW'(1);
        end
      end else if (pv_r) begin
        obuf_nxt[0] = pend_r;
        obuf_nxt[1] = plain;
        cnt_nxt     = (!in_tok.lead || in_tok.last) ? CW'(2) : CW'(1);
        pv_nxt      = in_tok.lead && !in_tok.last;
        pend_nxt    = in_tok.data;
      end else begin
        obuf_nxt[0] = plain;
        cnt_nxt     = (!in_tok.lead || in_tok.last) ? CW'(1) : CW'(0);
        pv_nxt      = in_tok.lead && !in_tok.last;
        pend_nxt    = in_tok.data;
      end
    end

    out_tok.data = obuf_r[0];
    out_tok.last = olast_r && (cnt_r == CW'(1));
    out_tok.lead = is_lead(NEXT_KIND, obuf_r[0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      pv_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      pv_r  <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obuf_r  <= obuf_nxt;
    olast_r <= olast_nxt;
    pend_r  <= pend_nxt;
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(REP_MAX))
    else $error("output buffer count out of range");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_tok.last |=> !pv_r)
    else $error("held byte survives message end");

  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_tok.last |=> cnt_r != '0)
    else $error("message end produced no byte");

  a_lf_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    KIND == PK_LF |-> !pv_r)
    else $error("line feed pass holds a byte");
`endif

endmodule

// ===== hdl/text_escape_transcoder_unit.sv =====
`timescale 1ns / 1ps
// Throughput: one output byte per cycle while out_stall is low; one input byte
// per cycle unless a pass emits more than one byte for one token, such as a pair
// that expands to five bytes or a held lead byte that did not match, which holds the input.
// Bound by the one-byte-per-cycle emit buffer of each pass stage.
// Reset: synchronous, active low; clears all held bytes and queues.
// ----------------------------------------------------------------------------
// text_escape_transcoder_unit
// Top level: front register, short queue, then a chain of five pass stages.
// ----------------------------------------------------------------------------
module text_escape_transcoder_unit #(
  parameter int QUEUE_DEPTH = tet_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);
  import tet_pkg::*;

  tok_t fr_tok, q_tok, a_tok, b_tok, c_tok, d_tok, e_tok;
  logic fr_valid, fr_stall, q_valid, q_stall;
  logic a_valid, a_stall, b_valid, b_stall, c_valid, c_stall, d_valid, d_stall;

  tet_front u_front (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_byte, .in_last,
    .out_valid(fr_valid), .out_stall(fr_stall), .out_tok(fr_tok)
  );

  tet_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n,
    .in_valid(fr_valid), .in_stall(fr_stall), .in_tok(fr_tok),
    .out_valid(q_valid), .out_stall(q_stall), .out_tok(q_tok)
  );

  tet_pass #(.KIND(PK_CONV), .NEXT_KIND(PK_NEW)) u_conv (
    .clk, .rst_n,
    .in_valid(q_valid), .in_stall(q_stall), .in_tok(q_tok),
    .out_valid(a_valid), .out_stall(a_stall), .out_tok(a_tok)
  );

  tet_pass #(.KIND(PK_NEW), .NEXT_KIND(PK_ESC)) u_new (
    .clk, .rst_n,
    .in_valid(a_valid), .in_stall(a_stall), .in_tok(a_tok),
    .out_valid(b_valid), .out_stall(b_stall), .out_tok(b_tok)
  );

  tet_pass #(.KIND(PK_ESC), .NEXT_KIND(PK_LF)) u_esc (
    .clk, .rst_n,
    .in_valid(b_valid), .in_stall(b_stall), .in_tok(b_tok),
    .out_valid(c_valid), .out_stall(c_stall), .out_tok(c_tok)
  );

  tet_pass #(.KIND(PK_LF), .NEXT_KIND(PK_HASH)) u_lf (
    .clk, .rst_n,
    .in_valid(c_valid), .in_stall(c_stall), .in_tok(c_tok),
    .out_valid(d_valid), .out_stall(d_stall), .out_tok(d_tok)
  );

  tet_pass #(.KIND(PK_HASH), .NEXT_KIND(PK_LF)) u_hash (
    .clk, .rst_n,
    .in_valid(d_valid), .in_stall(d_stall), .in_tok(d_tok),
    .out_valid, .out_stall, .out_tok(e_tok)
  );

  assign out_byte = e_tok.data;
  assign out_last = e_tok.last;

endmodule

// ===== sim/tb_text_escape_transcoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_escape_transcoder_unit
// Drives whole messages into the transcoder, predicts the transcoded byte
// stream with a software copy of the 59-stage replace chain, and compares
// every output transaction in order, with random idle and stall gaps in some phases.
// ----------------------------------------------------------------------------
module tb_text_escape_transcoder_unit;
  import tet_pkg::*;

  localparam int N_STAGE   = 59;
  localparam int STG_NEW0  = 16;
  localparam int STG_ESC0  = 33;
  localparam int STG_LF    = 57;
  localparam int CYC_LIMIT = 300000;

  localparam logic [7:0] UTF_LO [16] = '{
    8'hAA, 8'hA1, 8'hBF, 8'hAB, 8'hBB, 8'hA1, 8'hA9, 8'hAD,
    8'hB3, 8'hBA, 8'hB1, 8'h91, 8'hA7, 8'h87, 8'hBC, 8'h9C};
  localparam logic [7:0] GLYPH_LO [17] = '{
    8'hA0, 8'hA3, 8'hA4, 8'hA2, 8'hA8, 8'hAB, 8'hAA, 8'hAC,
    8'hAF, 8'hAE, 8'hB2, 8'hB5, 8'hB6, 8'hB4, 8'hB9, 8'hBB, 8'h9F};
  localparam logic [7:0] GLYPH_KEY [17] = '{
    8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd22, 8'd23,
    8'd24, 8'd25, 8'd26, 8'd27, 8'd28, 8'd29, 8'd30, 8'd31, 8'd35};
  localparam logic [7:0] ESC_CHR [24] = '{
    8'h67, 8'h74, 8'h62, 8'h73, 8'h66, 8'h6B, 8'h6E, 8'h72,
    8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48,
    8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50};
  localparam logic [7:0] ESC_CODE [24] = '{
    8'h0E, 8'h0F, 8'h0B, 8'h20, 8'h7F, 8'h0C, 8'h0D, 8'h0D,
    8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17,
    8'h18, 8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E, 8'h1F};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  logic [7:0] held_byte [N_STAGE];
  logic       held_vld [N_STAGE];
  logic [7:0] exp_byte_q [$];
  logic       exp_last_q [$];

  int errors = 0;
  int cycles = 0;
  int n_bytes = 0;
  int n_msgs = 0;
  int n_out = 0;
  int stall_cnt = 0;
  bit idle_on = 1'b0;

  text_escape_transcoder_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("%0t timeout with %0d transactions pending", $time, exp_byte_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  // search pair and replacement of one stage
  task automatic stage_rule(input int s, output logic [7:0] s0, output logic [7:0] s1,
                            output logic [7:0] rep [5], output int rlen);
    rep = '{default: 8'h00};
    if (s < STG_NEW0) begin
      s0 = (s < 5) ? CH_C2 : CH_C3;
      s1 = UTF_LO[s];
      rep[0] = 8'(16 + s);
      rlen = 1;
    end else if (s < STG_ESC0) begin
      s0 = CH_C3;
      s1 = GLYPH_LO[s - STG_NEW0];
      rep = '{CH_HASH, CH_G, GLYPH_KEY[s - STG_NEW0], CH_HASH, CH_T};
      rlen = 5;
    end else if (s < STG_LF) begin
      s0 = CH_HASH;
      s1 = ESC_CHR[s - STG_ESC0];
      rep[0] = ESC_CODE[s - STG_ESC0];
      rlen = 1;
    end else begin
      s0 = CH_HASH;
      s1 = CH_HASH;
      rep[0] = CH_HASH;
      rlen = 1;
    end
  endtask

  task automatic transcode_byte(input logic [7:0] b, input logic last);
    logic [7:0] cur [$];
    logic [7:0] nxt [$];
    logic [7:0] s0, s1, bt;
    logic [7:0] rep [5];
    int rlen;
    cur = '{b};
    for (int s = 0; s < N_STAGE; s++) begin
      nxt = {};
      if (s == STG_LF) begin
        foreach (cur[i]) nxt.push_back(cur[i] == CH_LF ? CH_CR : cur[i]);
      end else begin
        stage_rule(s, s0, s1, rep, rlen);
        foreach (cur[i]) begin
          bt = cur[i];
          if (held_vld[s] && bt == s1) begin
            for (int j = 0; j < rlen; j++) nxt.push_back(rep[j]);
            held_vld[s] = 1'b0;
          end else begin
            if (held_vld[s]) begin
              nxt.push_back(held_byte[s]);
              held_vld[s] = 1'b0;
            end
            if (bt == s0) begin
              held_byte[s] = bt;
              held_vld[s] = 1'b1;
            end else begin
              nxt.push_back(bt);
            end
          end
        end
        if (last && held_vld[s]) begin
          nxt.push_back(held_byte[s]);
          held_vld[s] = 1'b0;
        end
      end
      cur = nxt;
    end
    foreach (cur[i]) begin
      exp_byte_q.push_back(cur[i]);
      exp_last_q.push_back(last && (i == cur.size() - 1));
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte = b;
    in_last = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    transcode_byte(b, last);
    n_bytes++;
  endtask

  task automatic send_msg(input logic [7:0] msg [$]);
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
    n_msgs++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (exp_byte_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // hold output stalls between transactions
  always @(negedge clk) begin
    if (stall_cnt > 0) begin
      out_stall = 1'b1;
      stall_cnt = stall_cnt - 1;
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_out++;
      stall_cnt = idle_on ? $urandom_range(0, 9) : 0;
      if (exp_byte_q.size() == 0) begin
        $display("%0t unexpected transaction: actual byte=%02h last=%b", $time,
                 out_byte, out_last);
        errors++;
      end else begin
        if (out_byte !== exp_byte_q[0] || out_last !== exp_last_q[0]) begin
          $display("%0t mismatch: expected byte=%02h last=%b actual byte=%02h last=%b",
                   $time, exp_byte_q[0], exp_last_q[0], out_byte, out_last);
          errors++;
        end
        void'(exp_byte_q.pop_front());
        void'(exp_last_q.pop_front());
      end
    end
  end

  task automatic test_pairs();
    logic [7:0] m [$];
    m = {};
    for (int i = 0; i < 16; i++) m = {m, ((i < 5) ? CH_C2 : CH_C3), UTF_LO[i]};
    send_msg(m);
    m = {};
    for (int i = 0; i < 17; i++) m = {m, CH_C3, GLYPH_LO[i]};
    send_msg(m);
  endtask

  task automatic test_escapes();
    logic [7:0] m [$];
    m = {};
    for (int i = 0; i < 24; i++) m = {m, CH_HASH, ESC_CHR[i]};
    m = {m, CH_HASH, CH_HASH, CH_HASH, CH_LF, 8'h00, 8'hFF, CH_HASH};
    send_msg(m);
    send_msg('{CH_C2});
    send_msg('{CH_C3, CH_C3, CH_C3});
    send_msg('{CH_LF});
  endtask

  task automatic test_random(input int target);
    logic [7:0] m [$];
    int k, stop;
    stop = n_bytes + target;
    while (n_bytes < stop) begin
      m = {};
      repeat ($urandom_range(1, 6)) begin
        k = $urandom_range(0, 99);
        if (k < 15) begin
          k = $urandom_range(0, 15);
          m = {m, ((k < 5) ? CH_C2 : CH_C3), UTF_LO[k]};
        end else if (k < 30) m = {m, CH_C3, GLYPH_LO[$urandom_range(0, 16)]};
        else if (k < 45) m = {m, CH_HASH, ESC_CHR[$urandom_range(0, 23)]};
        else if (k < 65) m.push_back(8'($urandom_range(0, 255)));
        else if (k < 75) m.push_back(CH_HASH);
        else if (k < 85) m.push_back(($urandom_range(0, 1) != 0) ? CH_C2 : CH_C3);
        else if (k < 92) m.push_back(CH_LF);
        else m.push_back(8'($urandom_range(CH_UA, CH_UP)));
      end
      send_msg(m);
    end
  endtask

  initial begin
    for (int s = 0; s < N_STAGE; s++) begin
      held_byte[s] = 8'h00;
      held_vld[s] = 1'b0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_pairs();
    test_escapes();
    wait_drained();
    idle_on = 1'b1;
    test_random(10);
    wait_drained();
    idle_on = 1'b0;
    test_random(5);
    idle_on = 1'b1;
    test_random(10);
    wait_drained();

    $display("covered %0d messages, %0d input bytes, %0d output bytes", n_msgs, n_bytes,
             n_out);
    $display("all pair, glyph and escape rules, line feeds and held-byte flushes exercised");
    if (errors == 0 && exp_byte_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
